// ----- rtl/core/mi44_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi44_pkg
// Shared widths and index helpers for the 4x4 matrix inverse unit.
// ----------------------------------------------------------------------------
package mi44_pkg;

    localparam int ELEM_W = 32;
    localparam int ACC_W  = 192;
    localparam int COF_W  = 128;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // column order of the six terms of a 3x3 determinant, three positive then three negative
    function automatic logic [1:0] perm_col(input logic [2:0] term, input logic [1:0] row);
        logic [5:0] p;
        begin
            case (term)
                3'd0:    p = {2'd2, 2'd1, 2'd0};
                3'd1:    p = {2'd0, 2'd2, 2'd1};
                3'd2:    p = {2'd1, 2'd0, 2'd2};
                3'd3:    p = {2'd0, 2'd1, 2'd2};
                3'd4:    p = {2'd1, 2'd2, 2'd0};
                3'd5:    p = {2'd2, 2'd0, 2'd1};
                default: p = 6'd0;
            endcase
            case (row)
                2'd0:    perm_col = p[1:0];
                2'd1:    perm_col = p[3:2];
                default: perm_col = p[5:4];
            endcase
        end
    endfunction

    // n-th of the three rows or columns that remain once 'drop' is removed
    function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] drop);
        begin
            skip_idx = (n >= drop) ? n + 2'd1 : n;
        end
    endfunction

endpackage

// ----- rtl/core/matrix_inverse_4x4_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_unit
// 4x4 fixed-point matrix inverse by cofactors, one shared multiplier.
// ----------------------------------------------------------------------------
// Input beats on s_* write one element of a 16-entry row-major matrix store.
// A beat with index 15 writes its element and then starts the inversion; the
// store keeps its contents, so single elements can be rewritten and index 15
// sent again. s_tready is high only while the block is idle.
// The sixteen cofactors are built on one 33x33 multiplier with a 192-bit
// accumulator, then the determinant. Each result takes a restoring
// division, handed through the next, wait and output states. A zero
// determinant skips the divisions: sixteen zero results go out with
// singular set.
// Results leave on m_* in row-major order, m_tlast on the sixteenth. Each
// result is held in the output register until taken; a stalled receiver
// simply holds the sequencer. Reset clears the matrix store and the control.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // element_value[31:0], element_index[35:32], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value[31:0], result_index[35:32], zero pad
    output logic [1:0]  m_tuser,   // singular[0], saturated[1]
    output logic        m_tlast
);
    import mi44_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COF  = 3'd1;
    localparam logic [2:0] S_COFW = 3'd2;
    localparam logic [2:0] S_DET  = 3'd3;
    localparam logic [2:0] S_DETW = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;
    localparam logic [2:0] S_DIVW = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [3:0] cidx_reg, cidx_next;
    logic [2:0] term_reg, term_next;
    logic [1:0] stp_reg, stp_next;

    logic [ELEM_W-1:0] store_reg [16];
    logic [COF_W-1:0]  cof_reg [16];
    logic [ACC_W-1:0]  det_reg;
    logic              sing_reg;
    logic              neg_reg;

    logic [ELEM_W-1:0]        x_reg;
    logic [63:0]              p_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]         acc_reg, acc_sum;
    logic                     pend_en_reg, pend_en_next;
    logic                     pend_neg_reg, pend_neg_next;
    logic [1:0]               pend_sh_reg, pend_sh_next;

    logic [31:0] out_val_reg;
    logic        out_sat_reg;

    logic              in_beat;
    logic [3:0]        rd_addr;
    logic [ELEM_W-1:0] elem;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_y;
    logic [ACC_W-1:0]  pend_v;
    logic [1:0]        n_sel, row_r, col_c;
    logic [COF_W-1:0]  det_cof, div_cof;
    logic [31:0]       chunk;
    logic [COF_W-1:0]  cof_abs;
    logic [ACC_W-1:0]  det_abs;
    logic [ACC_W-1:0]  div_num, div_den, div_quo;
    logic              div_start, div_busy, div_done;
    logic              q_upper;
    logic [31:0]       q_lo;

    assign in_beat = s_tvalid && s_tready;
    assign row_r   = cidx_reg[3:2];
    assign col_c   = cidx_reg[1:0];
    assign n_sel   = (stp_reg == 2'd0) ? 2'd0 : (stp_reg == 2'd1) ? 2'd1 : 2'd2;

    always_comb
    begin
        if (state_reg == S_DET)
            rd_addr = {2'b00, cidx_reg[3:2]};
        else
            rd_addr = {skip_idx(n_sel, row_r), skip_idx(perm_col(term_reg, n_sel), col_c)};
    end

    assign elem    = store_reg[rd_addr];
    assign det_cof = cof_reg[cidx_reg[3:2]];
    assign chunk   = det_cof[cidx_reg[1:0]*32 +: 32];

    // multiplier operand select
    always_comb
    begin
        mul_b         = MUL_W'(signed'(elem));
        mul_a         = '0;
        pend_en_next  = 1'b0;
        pend_neg_next = 1'b0;
        pend_sh_next  = 2'd0;
        if (state_reg == S_COF)
        begin
            case (stp_reg)
                2'd1:
                begin
                    mul_a = MUL_W'(signed'(x_reg));
                end
                2'd2:
                begin
                    mul_a         = signed'({1'b0, prod_reg[31:0]});
                    pend_en_next  = 1'b1;
                    pend_neg_next = (term_reg >= 3'd3) ^ row_r[0] ^ col_c[0];
                end
                2'd3:
                begin
                    mul_a         = MUL_W'(signed'(p_reg[63:32]));
                    pend_en_next  = 1'b1;
                    pend_neg_next = (term_reg >= 3'd3) ^ row_r[0] ^ col_c[0];
                    pend_sh_next  = 2'd1;
                end
                default:
                begin
                    mul_a = '0;
                end
            endcase
        end
        else if (state_reg == S_DET)
        begin
            if (cidx_reg[1:0] == 2'd3)
                mul_a = MUL_W'(signed'(chunk));
            else
                mul_a = signed'({1'b0, chunk});
            pend_en_next = 1'b1;
            pend_sh_next = cidx_reg[1:0];
        end
    end

    assign mul_y = mul_a * mul_b;

    // accumulate the registered product, shifted by whole 32-bit limbs
    always_comb
    begin
        pend_v = ACC_W'(prod_reg) << (32 * pend_sh_reg);
        if (!pend_en_reg)
            acc_sum = acc_reg;
        else if (pend_neg_reg)
            acc_sum = acc_reg - pend_v;
        else
            acc_sum = acc_reg + pend_v;
    end

    // divider operands: |cofactor(j,i)| << 2F over |det|
    assign div_cof = cof_reg[{cidx_reg[1:0], cidx_reg[3:2]}];
    assign cof_abs = div_cof[COF_W-1] ? COF_W'(-div_cof) : div_cof;
    assign det_abs = det_reg[ACC_W-1] ? ACC_W'(-det_reg) : det_reg;
    assign div_num = ACC_W'(cof_abs) << (2 * FRAC_BITS);
    assign div_den = det_abs;
    assign div_start = (state_reg == S_NEXT) && !sing_reg;

    mi44_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign q_upper = |div_quo[ACC_W-1:32];
    assign q_lo    = div_quo[31:0];

    always_comb
    begin
        state_next = state_reg;
        cidx_next  = cidx_reg;
        term_next  = term_reg;
        stp_next   = stp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat && (s_tdata[35:32] == 4'd15))
                begin
                    state_next = S_COF;
                    cidx_next  = 4'd0;
                    term_next  = 3'd0;
                    stp_next   = 2'd0;
                end
            end
            S_COF:
            begin
                stp_next = stp_reg + 2'd1;
                if (stp_reg == 2'd3)
                begin
                    if (term_reg == 3'd5)
                        state_next = S_COFW;
                    else
                        term_next = term_reg + 3'd1;
                end
            end
            S_COFW:
            begin
                term_next = 3'd0;
                stp_next  = 2'd0;
                cidx_next = cidx_reg + 4'd1;
                state_next = (cidx_reg == 4'd15) ? S_DET : S_COF;
            end
            S_DET:
            begin
                cidx_next = cidx_reg + 4'd1;
                if (cidx_reg == 4'd15)
                    state_next = S_DETW;
            end
            S_DETW:
            begin
                cidx_next  = 4'd0;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = sing_reg ? S_OUT : S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    cidx_next  = cidx_reg + 4'd1;
                    state_next = (cidx_reg == 4'd15) ? S_IDLE : S_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cidx_reg     <= '0;
            term_reg     <= '0;
            stp_reg      <= '0;
            pend_en_reg  <= 1'b0;
            pend_neg_reg <= 1'b0;
            pend_sh_reg  <= '0;
            for (int i = 0; i < 16; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cidx_reg     <= cidx_next;
            term_reg     <= term_next;
            stp_reg      <= stp_next;
            pend_en_reg  <= pend_en_next;
            pend_neg_reg <= pend_neg_next;
            pend_sh_reg  <= pend_sh_next;
            if (in_beat)
                store_reg[s_tdata[35:32]] <= s_tdata[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_y;
        if (state_reg == S_COF && stp_reg == 2'd0)
            x_reg <= elem;
        if (state_reg == S_COF && stp_reg == 2'd2)
            p_reg <= prod_reg[63:0];
        if (state_reg == S_IDLE || state_reg == S_COFW || state_reg == S_DETW)
            acc_reg <= '0;
        else
            acc_reg <= acc_sum;
        if (state_reg == S_COFW)
            cof_reg[cidx_reg] <= acc_sum[COF_W-1:0];
        // the determinant can need more than 128 bits, keep the full accumulator
        if (state_reg == S_DETW)
        begin
            det_reg  <= acc_sum;
            sing_reg <= (acc_sum == '0);
        end
        if (div_start)
            neg_reg <= div_cof[COF_W-1] ^ det_reg[ACC_W-1];
        if (state_reg == S_NEXT && sing_reg)
        begin
            out_val_reg <= '0;
            out_sat_reg <= 1'b0;
        end
        else if (state_reg == S_DIVW && div_done)
        begin
            if (!neg_reg)
            begin
                out_sat_reg <= q_upper || q_lo[31];
                out_val_reg <= (q_upper || q_lo[31]) ? 32'h7FFF_FFFF : q_lo;
            end
            else
            begin
                out_sat_reg <= q_upper || (q_lo > 32'h8000_0000);
                out_val_reg <= (q_upper || (q_lo > 32'h8000_0000)) ? 32'h8000_0000 : 32'(-q_lo);
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'd0, cidx_reg, out_val_reg};
    assign m_tuser  = {out_sat_reg, sing_reg};
    assign m_tlast  = (cidx_reg == 4'd15);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'd0 && !m_tuser[1]))
        else $error("singular result not zero");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after last result");

    a_div_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIVW))
        else $error("divider running outside its wait state");

endmodule

// ----- rtl/core/mi44_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi44_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mi44_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mi44_pkg::ACC_W-1:0]  num,
    input  logic [mi44_pkg::ACC_W-1:0]  den,
    output logic                        busy,
    output logic                        done,
    output logic [mi44_pkg::ACC_W-1:0]  quo
);
    import mi44_pkg::*;

    localparam int CW = $clog2(ACC_W);

    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ACC_W-1:0] rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[ACC_W-2:0], quo_reg[ACC_W-1]};
    assign fits   = rem_sh >= den;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CW'(ACC_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out of the top as quotient bits shift in
            rem_next = fits ? rem_sh - den : rem_sh;
            quo_next = {quo_reg[ACC_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x4 fixed-point matrix inverse unit.
// ----------------------------------------------------------------------------
// Element beats are streamed in, and each index-15 beat starts an inversion.
// A short table of directed beats comes first: the singular store after reset,
// the identity, a tiny diagonal that clamps high or low, and extreme elements.
// Random matrices follow. Their content is full range, near unit scale,
// diagonal heavy with row elements copied, at times singular. Some runs rewrite only a
// few elements, and some beats are loose writes. An exact wide-integer model of
// adj/det predicts results; directed singular and diagonal rows queue theirs.
// Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module testbench;

    typedef logic signed [191:0] wide_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_SINGULAR, ROW_DIAG} row_kind_t;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        row_kind_t   kind;
        logic [31:0] diag;
        logic        diag_sat;
    } stim_row_t;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        singular;
        logic        saturated;
        logic        last;
    } inv_beat_t;

    localparam int FRAC = 16;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic signed [31:0] shadow_store [16];
    inv_beat_t          pending_inv [$];
    int                 error_count;
    bit                 no_stall;

    matrix_inverse_4x4_unit #(.FRAC_BITS(FRAC)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL matrix_inverse_4x4_unit");
        $finish;
    end

    // signed cofactor of the shadow store at (r, c)
    function automatic wide_t cofactor_of(input int r, input int c);
        int    rr [3];
        int    cc [3];
        int    n;
        wide_t e [3][3];
        wide_t acc;
        n = 0;
        for (int k = 0; k < 4; k++)
        begin
            if (k != r)
            begin
                rr[n] = k;
                n++;
            end
        end
        n = 0;
        for (int k = 0; k < 4; k++)
        begin
            if (k != c)
            begin
                cc[n] = k;
                n++;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                e[a][b] = wide_t'(shadow_store[rr[a] * 4 + cc[b]]);
            end
        end
        acc = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
            - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
            + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
        if (((r + c) & 1) != 0)
        begin
            acc = -acc;
        end
        return acc;
    endfunction

    // queue the sixteen beats of adj/det for the current shadow store
    task automatic predict_inverse();
        wide_t     cof [16];
        wide_t     det;
        wide_t     q;
        inv_beat_t b;
        for (int k = 0; k < 16; k++)
        begin
            cof[k] = cofactor_of(k / 4, k % 4);
        end
        det = '0;
        for (int c = 0; c < 4; c++)
        begin
            det += wide_t'(shadow_store[c]) * cof[c];
        end
        for (int k = 0; k < 16; k++)
        begin
            b.index     = 4'(k);
            b.last      = (k == 15);
            b.singular  = (det == 0);
            b.saturated = 1'b0;
            b.value     = '0;
            if (det != 0)
            begin
                // signed division truncates toward zero
                q = (cof[(k % 4) * 4 + k / 4] <<< (2 * FRAC)) / det;
                if (q > wide_t'(32'sh7FFF_FFFF))
                begin
                    b.value     = 32'h7FFF_FFFF;
                    b.saturated = 1'b1;
                end
                else if (q < -wide_t'(64'sh8000_0000))
                begin
                    b.value     = 32'h8000_0000;
                    b.saturated = 1'b1;
                end
                else
                begin
                    b.value = q[31:0];
                end
            end
            pending_inv.push_back(b);
        end
    endtask

    task automatic push_typed(input row_kind_t kind, input logic [31:0] diag, input logic sat);
        inv_beat_t b;
        for (int k = 0; k < 16; k++)
        begin
            b.index     = 4'(k);
            b.last      = (k == 15);
            b.singular  = (kind == ROW_SINGULAR);
            b.saturated = (kind == ROW_DIAG) && sat && (k % 5 == 0);
            b.value     = (kind == ROW_DIAG && k % 5 == 0) ? diag : 32'h0;
            pending_inv.push_back(b);
        end
    endtask

    task automatic send_element(input logic [31:0] value, input logic [3:0] index,
                                input row_kind_t kind, input logic [31:0] diag,
                                input logic sat);
        while (!no_stall && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, index, value};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        shadow_store[index] = value;
        if (index == 4'd15)
        begin
            if (kind == ROW_PREDICT)
            begin
                predict_inverse();
            end
            else
            begin
                push_typed(kind, diag, sat);
            end
        end
    endtask

    function automatic logic [31:0] random_element(input int style);
        case (style)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
            default: return 32'($signed($urandom_range(2 << FRAC)) - (1 << FRAC));
        endcase
    endfunction

    // receive side: random stall, compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        m_tready <= no_stall || ($urandom_range(99) >= 14);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_inv.size() == 0)
            begin
                $error("unexpected result beat index %0d", m_tdata[35:32]);
                error_count++;
            end
            else
            begin
                inv_beat_t b;
                b = pending_inv.pop_front();
                if (m_tdata[31:0] !== b.value)
                begin
                    $error("result_value exp %h got %h", b.value, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[35:32] !== b.index)
                begin
                    $error("result_index exp %0d got %0d", b.index, m_tdata[35:32]);
                    error_count++;
                end
                if (m_tuser[0] !== b.singular)
                begin
                    $error("singular exp %b got %b", b.singular, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== b.saturated)
                begin
                    $error("saturated exp %b got %b", b.saturated, m_tuser[1]);
                    error_count++;
                end
                if (m_tlast !== b.last)
                begin
                    $error("last_result exp %b got %b", b.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t directed [] = '{
            // store is zero after reset: singular
            '{32'h0, 4'd15, ROW_SINGULAR, 32'h0, 1'b0},
            // identity
            '{ONE, 4'd0,  ROW_PREDICT, 32'h0, 1'b0},
            '{ONE, 4'd5,  ROW_PREDICT, 32'h0, 1'b0},
            '{ONE, 4'd10, ROW_PREDICT, 32'h0, 1'b0},
            '{ONE, 4'd15, ROW_DIAG, ONE, 1'b0},
            // smallest positive diagonal: clamps high
            '{32'h1, 4'd0,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h1, 4'd5,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h1, 4'd10, ROW_PREDICT, 32'h0, 1'b0},
            '{32'h1, 4'd15, ROW_DIAG, 32'h7FFF_FFFF, 1'b1},
            // minus one lsb diagonal: clamps low
            '{32'hFFFF_FFFF, 4'd0,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'hFFFF_FFFF, 4'd5,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'hFFFF_FFFF, 4'd10, ROW_PREDICT, 32'h0, 1'b0},
            '{32'hFFFF_FFFF, 4'd15, ROW_DIAG, 32'h8000_0000, 1'b1},
            // extreme elements, off-diagonal terms included
            '{32'h7FFF_FFFF, 4'd0,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h8000_0000, 4'd5,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h7FFF_FFFF, 4'd3,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h8000_0000, 4'd12, ROW_PREDICT, 32'h0, 1'b0},
            '{32'h8000_0000, 4'd15, ROW_PREDICT, 32'h0, 1'b0},
            // second row set to the first but for column 1: not singular, nonzero data
            '{32'h7FFF_FFFF, 4'd4,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'hFFFF_FFFF, 4'd5,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h0,         4'd6,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h7FFF_FFFF, 4'd7,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h7FFF_FFFF, 4'd0,  ROW_PREDICT, 32'h0, 1'b0},
            '{32'h0,         4'd2,  ROW_PREDICT, 32'h0, 1'b0},
            '{ONE,           4'd15, ROW_PREDICT, 32'h0, 1'b0}
        };
        int sent;
        int style;
        int drain;

        error_count = 0;
        no_stall    = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            shadow_store[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            send_element(directed[n].value, directed[n].index, directed[n].kind,
                         directed[n].diag, directed[n].diag_sat);
        end

        sent = 0;
        while (sent < 145)
        begin
            // a stretch in the middle runs with no stalls on either side
            no_stall = (sent >= 70 && sent < 110);
            style    = $urandom_range(3);
            case ($urandom_range(9))
                0, 1:
                begin
                    // rewrite a few elements, then invert again
                    repeat ($urandom_range(1, 4))
                    begin
                        send_element(random_element(style % 3), 4'($urandom_range(14)),
                                     ROW_PREDICT, 32'h0, 1'b0);
                        sent++;
                    end
                    send_element(random_element(style % 3), 4'd15, ROW_PREDICT, 32'h0, 1'b0);
                    sent++;
                end
                2:
                begin
                    // loose beat with any index
                    send_element($urandom, 4'($urandom_range(15)), ROW_PREDICT, 32'h0, 1'b0);
                    sent++;
                end
                default:
                begin
                    for (int k = 0; k < 16; k++)
                    begin
                        logic [31:0] v;
                        if (style == 3)
                        begin
                            // diagonal heavy; row 1 elements may be copied from row 0, singular if all are
                            v = (k % 5 == 0) ? random_element(1) + (8 << FRAC)
                                             : random_element(2);
                            if (k >= 4 && k < 8 && $urandom_range(1) == 1)
                            begin
                                v = shadow_store[k - 4];
                            end
                        end
                        else
                        begin
                            v = random_element(style);
                        end
                        send_element(v, 4'(k), ROW_PREDICT, 32'h0, 1'b0);
                        sent++;
                    end
                end
            endcase
        end
        // drop valid right after the last accepted beat so it is not taken twice
        s_tvalid <= 1'b0;
        no_stall = 1'b0;

        wait (pending_inv.size() == 0);
        drain = 0;
        while (drain < 400)
        begin
            @(posedge clk);
            drain++;
        end
        if (error_count == 0)
        begin
            $display("PASS matrix_inverse_4x4_unit");
        end
        else
        begin
            $display("FAIL matrix_inverse_4x4_unit");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mi44_pkg.sv
rtl/core/mi44_div.sv
rtl/core/matrix_inverse_4x4_unit.sv
tb/testbench.sv
